[hw/rtl/eks_pkg.sv]
// eks_pkg: shared types, constants and the exponential table of the point smoother
// used by the channel interfaces, the top level and the checker
// no dependencies
package eks_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int EXP_BITS       = 20;

  // register indexes on the configuration port
  localparam logic REG_SMOOTH = 1'b0;
  localparam logic REG_CUTOFF = 1'b1;

  localparam logic [31:0] SMOOTH_RST = 32'd65536;
  localparam logic [31:0] CUTOFF_RST = 32'd196608;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               final_point;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               last_out;
    logic               overflow;
  } out_item_t;

  typedef enum logic [4:0] {
    S_LOAD,
    S_RD_I,
    S_WAIT_I,
    S_NEXT_J,
    S_WAIT_J,
    S_DIFF,
    S_SQ,
    S_CMP,
    S_SQRT,
    S_DIV_START,
    S_DIV_WAIT,
    S_EXP,
    S_ACC,
    S_MEAN_START,
    S_MEAN_WAIT,
    S_OUT
  } state_t;

  // round(2^32 * exp(-2^(k-16)))
  function automatic logic [31:0] exp_tab(input logic [4:0] k);
    logic [31:0] t;
    case (k)
      5'd0:    t = 32'd4294901760;
      5'd1:    t = 32'd4294836226;
      5'd2:    t = 32'd4294705160;
      5'd3:    t = 32'd4294443040;
      5'd4:    t = 32'd4293918848;
      5'd5:    t = 32'd4292870656;
      5'd6:    t = 32'd4290775039;
      5'd7:    t = 32'd4286586875;
      5'd8:    t = 32'd4278222805;
      5'd9:    t = 32'd4261543595;
      5'd10:   t = 32'd4228380000;
      5'd11:   t = 32'd4162825044;
      5'd12:   t = 32'd4034877432;
      5'd13:   t = 32'd3790295335;
      5'd14:   t = 32'd3344923893;
      5'd15:   t = 32'd2605029347;
      5'd16:   t = 32'd1580030169;
      5'd17:   t = 32'd581260615;
      5'd18:   t = 32'd78665070;
      5'd19:   t = 32'd1440801;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

[hw/rtl/eks_if.sv]
// eks_if: valid/ready channel interfaces for input points and smoothed results
// depends on eks_pkg for the item types
interface eks_in_if;
  logic               valid;
  logic               ready;
  eks_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface eks_out_if;
  logic               valid;
  logic               ready;
  eks_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/eks_div.sv]
// eks_div: 64 by 32 bit unsigned restoring divider, one quotient bit per cycle
// depends on nothing but the clock and reset
module eks_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quot
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [31:0] rem_r;
  logic [63:0] qd_r;
  logic [31:0] dsr_r;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        ge;

  // one restoring step
  always_comb begin
    rem_sh  = {rem_r, qd_r[63]};
    ge      = rem_sh >= {1'b0, dsr_r};
    rem_sub = rem_sh - {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      qd_r  <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[31:0] : rem_sh[31:0];
      qd_r  <= {qd_r[62:0], ge};
    end
  end

  assign done = done_r;
  assign quot = qd_r;

endmodule

[hw/rtl/exponential_kernel_point_smoothing.sv]
// exponential_kernel_point_smoothing: top level of the point smoother
// depends on eks_pkg, eks_if (channel interfaces) and eks_div
// flow: load items are taken while loading; on the final item each point walks all others;
// a neighbor inside the cutoff passes control, square, root, divider, exp and accumulate steps
// (no exp steps when the ratio is 16 or more), one rejected early skips the rest, then the
// divider runs once per axis for its mean, followed by read, loop and output, plus stalls
// input: one item at a time; no input is taken while a set is smoothed or emitted
// reset: synchronous active-low rst_n clears control state; point memory needs no clear
module exponential_kernel_point_smoothing #(
  parameter int MAX_POINTS = eks_pkg::MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  eks_in_if.sink      in_ch,
  eks_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  eks_pkg::state_t state_r, state_nxt;

  logic [31:0]        smooth_r;
  logic [31:0]        cutoff_r;
  logic [CW-1:0]      cnt_r;
  logic               drop_r;
  logic [IW-1:0]      i_r;
  logic [CW-1:0]      j_r;
  logic [1:0]         ax_r;
  logic [4:0]         k_r;

  logic [95:0]        mem [MAX_POINTS];
  logic [95:0]        rd_q_r;
  logic [IW-1:0]      rd_addr;

  logic signed [31:0] pi_r [3];
  logic signed [31:0] pj_r [3];
  logic [31:0]        mag_r [3];
  logic [65:0]        d2_r;
  logic [63:0]        cut2_r;
  logic [63:0]        rem_r, root_r, bit_r;
  logic [19:0]        x_r;
  logic [32:0]        acc_r;
  logic [16:0]        w_r;
  logic signed [63:0] sum_r [3];
  logic [31:0]        ws_r;
  logic [31:0]        res_r [3];

  logic               in_acc;
  logic               last_pt;
  logic               div_start;
  logic [63:0]        div_dvd;
  logic [31:0]        div_dsr;
  logic               div_done;
  logic [63:0]        div_q;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == eks_pkg::REG_CUTOFF) ? cutoff_r : smooth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= eks_pkg::SMOOTH_RST;
      cutoff_r <= eks_pkg::CUTOFF_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == eks_pkg::REG_CUTOFF) cutoff_r <= pwdata;
      else smooth_r <= pwdata;
    end
  end

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign last_pt = (CW'(i_r) == cnt_r - CW'(1));

  // pair distance terms
  logic signed [32:0] diff [3];
  logic [32:0]        dmag [3];
  logic               too_far;
  always_comb begin
    too_far = 1'b0;
    for (int a = 0; a < 3; a++) begin
      diff[a] = {pi_r[a][31], pi_r[a]} - {pj_r[a][31], pj_r[a]};
      dmag[a] = diff[a][32] ? 33'(-diff[a]) : diff[a];
      if (dmag[a] > {1'b0, cutoff_r}) too_far = 1'b1;
    end
  end

  // shared squarer
  logic [31:0] sq_op;
  logic [63:0] sq_p;
  always_comb begin
    sq_op = (ax_r == 2'd3) ? cutoff_r : mag_r[ax_r];
    sq_p  = sq_op * sq_op;
  end

  // root step
  logic [63:0] trial;
  logic        root_ge;
  assign trial   = root_r + bit_r;
  assign root_ge = rem_r >= trial;

  // exp step
  logic [64:0] exp_p;
  logic [64:0] exp_rnd;
  always_comb begin
    exp_p   = acc_r * eks_pkg::exp_tab(k_r);
    exp_rnd = exp_p + 65'h0_8000_0000;
  end

  logic [33:0] w_full;
  assign w_full = {1'b0, acc_r} + 34'h0_0000_8000;

  // weight from the final exp accumulator value
  function automatic logic [16:0] w_full_f(input logic [32:0] a);
    logic [33:0] s;
    s = {1'b0, a} + 34'h0_0000_8000;
    return s[32:16];
  endfunction

  // weighted neighbour term
  logic signed [49:0] acc_p;
  assign acc_p = pj_r[ax_r] * $signed({1'b0, w_r});

  // rounded mean input and clamp
  logic [63:0] smag;
  logic [63:0] qc;
  logic [31:0] mean_v;
  always_comb begin
    smag    = sum_r[ax_r][63] ? 64'(-sum_r[ax_r]) : sum_r[ax_r];
    if (sum_r[ax_r][63]) begin
      qc     = (div_q > 64'h8000_0000) ? 64'h8000_0000 : div_q;
      mean_v = 32'(-qc);
    end else begin
      qc     = (div_q > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : div_q;
      mean_v = qc[31:0];
    end
  end

  // divider operands
  always_comb begin
    if (state_r == eks_pkg::S_DIV_START) begin
      div_dvd = {16'b0, root_r[31:0], 16'b0};
      div_dsr = smooth_r;
    end else begin
      div_dvd = smag + {33'b0, ws_r[31:1]};
      div_dsr = ws_r;
    end
  end

  eks_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quot     (div_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      eks_pkg::S_LOAD:       if (in_acc && in_ch.data.final_point) state_nxt = eks_pkg::S_RD_I;
      eks_pkg::S_RD_I:       state_nxt = eks_pkg::S_WAIT_I;
      eks_pkg::S_WAIT_I:     state_nxt = eks_pkg::S_NEXT_J;
      eks_pkg::S_NEXT_J: begin
        if (smooth_r == '0 || j_r == cnt_r) state_nxt = eks_pkg::S_MEAN_START;
        else if (j_r[IW-1:0] != i_r) state_nxt = eks_pkg::S_WAIT_J;
      end
      eks_pkg::S_WAIT_J:     state_nxt = eks_pkg::S_DIFF;
      eks_pkg::S_DIFF:       state_nxt = too_far ? eks_pkg::S_NEXT_J : eks_pkg::S_SQ;
      eks_pkg::S_SQ:         if (ax_r == 2'd3) state_nxt = eks_pkg::S_CMP;
      eks_pkg::S_CMP: begin
        if (d2_r[65:64] != 2'b0 || d2_r[63:0] > cut2_r) state_nxt = eks_pkg::S_NEXT_J;
        else state_nxt = eks_pkg::S_SQRT;
      end
      eks_pkg::S_SQRT:       if (k_r == 5'd31) state_nxt = eks_pkg::S_DIV_START;
      eks_pkg::S_DIV_START:  state_nxt = eks_pkg::S_DIV_WAIT;
      eks_pkg::S_DIV_WAIT: begin
        if (div_done) state_nxt = (div_q[63:20] != '0) ? eks_pkg::S_ACC : eks_pkg::S_EXP;
      end
      eks_pkg::S_EXP:        if (k_r == 5'(eks_pkg::EXP_BITS - 1)) state_nxt = eks_pkg::S_ACC;
      eks_pkg::S_ACC:        if (ax_r == 2'd2) state_nxt = eks_pkg::S_NEXT_J;
      eks_pkg::S_MEAN_START: state_nxt = eks_pkg::S_MEAN_WAIT;
      eks_pkg::S_MEAN_WAIT: begin
        if (div_done) state_nxt = (ax_r == 2'd2) ? eks_pkg::S_OUT : eks_pkg::S_MEAN_START;
      end
      eks_pkg::S_OUT: begin
        if (out_ch.ready) state_nxt = last_pt ? eks_pkg::S_LOAD : eks_pkg::S_RD_I;
      end
      default:               state_nxt = eks_pkg::S_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready  = (state_r == eks_pkg::S_LOAD);
    out_ch.valid = (state_r == eks_pkg::S_OUT);
    div_start    = (state_r == eks_pkg::S_DIV_START) || (state_r == eks_pkg::S_MEAN_START);
    rd_addr      = (state_r == eks_pkg::S_RD_I) ? i_r : j_r[IW-1:0];
  end

  assign out_ch.data = '{out_x: res_r[0], out_y: res_r[1], out_z: res_r[2],
                         last_out: last_pt, overflow: drop_r};

  // point memory
  always_ff @(posedge clk) begin
    if (in_acc && cnt_r != CW'(MAX_POINTS))
      mem[cnt_r[IW-1:0]] <= {in_ch.data.pos_z, in_ch.data.pos_y, in_ch.data.pos_x};
    rd_q_r <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= eks_pkg::S_LOAD;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
      i_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (cnt_r != CW'(MAX_POINTS)) cnt_r <= cnt_r + CW'(1);
        else drop_r <= 1'b1;
      end
      if (state_r == eks_pkg::S_OUT && out_ch.ready) begin
        if (last_pt) begin
          cnt_r  <= '0;
          drop_r <= 1'b0;
          i_r    <= '0;
        end else begin
          i_r <= i_r + IW'(1);
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      eks_pkg::S_WAIT_I: begin
        for (int a = 0; a < 3; a++) begin
          pi_r[a]  <= rd_q_r[32*a +: 32];
          sum_r[a] <= {{16{rd_q_r[32*a+31]}}, rd_q_r[32*a +: 32], 16'b0};
        end
        ws_r <= 32'd65536;
        j_r  <= '0;
      end
      eks_pkg::S_NEXT_J: begin
        if (j_r[IW-1:0] == i_r && j_r != cnt_r) j_r <= j_r + CW'(1);
        ax_r <= '0;
      end
      eks_pkg::S_WAIT_J: begin
        for (int a = 0; a < 3; a++) pj_r[a] <= rd_q_r[32*a +: 32];
      end
      eks_pkg::S_DIFF: begin
        for (int a = 0; a < 3; a++) mag_r[a] <= dmag[a][31:0];
        d2_r <= '0;
        ax_r <= '0;
        if (too_far) j_r <= j_r + CW'(1);
      end
      eks_pkg::S_SQ: begin
        if (ax_r == 2'd3) cut2_r <= sq_p;
        else d2_r <= d2_r + {2'b0, sq_p};
        ax_r <= ax_r + 2'd1;
      end
      eks_pkg::S_CMP: begin
        rem_r  <= d2_r[63:0];
        root_r <= '0;
        bit_r  <= 64'h4000_0000_0000_0000;
        k_r    <= '0;
        if (d2_r[65:64] != 2'b0 || d2_r[63:0] > cut2_r) j_r <= j_r + CW'(1);
      end
      eks_pkg::S_SQRT: begin
        if (root_ge) begin
          rem_r  <= rem_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        k_r   <= k_r + 5'd1;
      end
      eks_pkg::S_DIV_WAIT: begin
        x_r   <= div_q[19:0];
        acc_r <= 33'h1_0000_0000;
        k_r   <= '0;
        ax_r  <= '0;
        if (div_q[63:20] != '0) w_r <= '0;
      end
      eks_pkg::S_EXP: begin
        if (x_r[k_r]) acc_r <= exp_rnd[64:32];
        k_r  <= k_r + 5'd1;
        if (k_r == 5'(eks_pkg::EXP_BITS - 1)) begin
          w_r <= x_r[k_r] ? w_full_f(exp_rnd[64:32]) : w_full[32:16];
        end
      end
      eks_pkg::S_ACC: begin
        sum_r[ax_r] <= sum_r[ax_r] + 64'(acc_p);
        ax_r        <= ax_r + 2'd1;
        if (ax_r == 2'd2) begin
          ws_r <= ws_r + {15'b0, w_r};
          j_r  <= j_r + CW'(1);
        end
      end
      eks_pkg::S_MEAN_WAIT: begin
        if (div_done) begin
          res_r[ax_r] <= mean_v;
          ax_r        <= ax_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/eks_chk.sv]
// eks_chk: port-level checks for the point smoother, bound to the top level
// depends on eks_pkg for the result item type
module eks_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input eks_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // no point is taken while a result is shown
  a_no_load_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // after the last result the block loads again
  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_out |=> in_ready && !out_valid)
    else $error("no return to loading after last result");

endmodule

bind exponential_kernel_point_smoothing eks_chk u_eks_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

[tb/sv/exponential_kernel_point_smoothing_tb.sv]
// exponential_kernel_point_smoothing_tb: self-checking bench for the point smoother
// drives point sets and register writes, predicts every smoothed result and checks it
// depends on eks_pkg, eks_if and the exponential_kernel_point_smoothing top level
module exponential_kernel_point_smoothing_tb;

  localparam int NPTS        = eks_pkg::MAX_POINTS_DEF;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int ITEM_GOAL   = 420;
  localparam int QUIET_ITEMS = 60;

  localparam logic [31:0] DECAY_TAB [eks_pkg::EXP_BITS] = '{
    32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040, 32'd4293918848,
    32'd4292870656, 32'd4290775039, 32'd4286586875, 32'd4278222805, 32'd4261543595,
    32'd4228380000, 32'd4162825044, 32'd4034877432, 32'd3790295335, 32'd3344923893,
    32'd2605029347, 32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801
  };

  // expected smoothed points of the current and past sets
  class smoothing_scoreboard;
    logic [31:0]         decay_len;
    logic [31:0]         cut_radius;
    logic signed [31:0]  pts_x [NPTS];
    logic signed [31:0]  pts_y [NPTS];
    logic signed [31:0]  pts_z [NPTS];
    int                  loaded;
    bit                  dropped;
    eks_pkg::out_item_t  smoothed_q [$];
    int                  mismatches;
    int                  checked;
    int                  sets_done;

    function new();
      decay_len  = eks_pkg::SMOOTH_RST;
      cut_radius = eks_pkg::CUTOFF_RST;
      loaded     = 0;
      dropped    = 0;
      mismatches = 0;
      checked    = 0;
      sets_done  = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == eks_pkg::REG_SMOOTH) decay_len = val;
      else cut_radius = val;
    endfunction

    // kernel weight of a pair, -1 when outside the cutoff
    function longint pair_kernel(int a, int b);
      longint            dif [3];
      longint unsigned   mag, cut2, rem, root, bt, ratio, acc;
      logic [65:0]       d2;
      dif[0] = longint'(pts_x[a]) - longint'(pts_x[b]);
      dif[1] = longint'(pts_y[a]) - longint'(pts_y[b]);
      dif[2] = longint'(pts_z[a]) - longint'(pts_z[b]);
      cut2 = longint'(cut_radius) * longint'(cut_radius);
      d2 = '0;
      for (int k = 0; k < 3; k++) begin
        mag = (dif[k] < 0) ? -dif[k] : dif[k];
        if (mag > cut_radius) return -1;
        d2 = d2 + {2'b0, mag * mag};
      end
      if (d2[65:64] != 2'b0 || d2[63:0] > cut2) return -1;
      // bitwise integer square root
      rem = d2[63:0];
      root = 0;
      bt = 64'h4000_0000_0000_0000;
      for (int k = 0; k < 32; k++) begin
        if (rem >= root + bt) begin
          rem = rem - (root + bt);
          root = (root >> 1) + bt;
        end else begin
          root = root >> 1;
        end
        bt = bt >> 2;
      end
      ratio = (root << 16) / decay_len;
      if (ratio >= (64'd1 << eks_pkg::EXP_BITS)) return 0;
      acc = 64'd1 << 32;
      for (int k = 0; k < eks_pkg::EXP_BITS; k++)
        if (ratio[k]) acc = (acc * DECAY_TAB[k] + (64'd1 << 31)) >> 32;
      return longint'((acc + 64'd32768) >> 16);
    endfunction

    function logic [31:0] rounded_mean(longint sum, longint unsigned wsum);
      longint unsigned q;
      q = (((sum < 0) ? -sum : sum) + wsum / 2) / wsum;
      if (sum < 0) begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        return 32'(-q);
      end
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return q[31:0];
    endfunction

    function void note_input(eks_pkg::in_item_t it);
      longint             sx [NPTS];
      longint             sy [NPTS];
      longint             sz [NPTS];
      longint unsigned    ws [NPTS];
      longint             w;
      eks_pkg::out_item_t r;
      if (loaded < NPTS) begin
        pts_x[loaded] = it.pos_x;
        pts_y[loaded] = it.pos_y;
        pts_z[loaded] = it.pos_z;
        loaded++;
      end else begin
        dropped = 1;
      end
      if (!it.final_point) return;
      for (int i = 0; i < loaded; i++) begin
        sx[i] = longint'(pts_x[i]) * 65536;
        sy[i] = longint'(pts_y[i]) * 65536;
        sz[i] = longint'(pts_z[i]) * 65536;
        ws[i] = 65536;
      end
      if (decay_len != 0) begin
        for (int i = 0; i + 1 < loaded; i++) begin
          for (int j = i + 1; j < loaded; j++) begin
            w = pair_kernel(i, j);
            if (w >= 0) begin
              sx[i] += longint'(pts_x[j]) * w;
              sy[i] += longint'(pts_y[j]) * w;
              sz[i] += longint'(pts_z[j]) * w;
              sx[j] += longint'(pts_x[i]) * w;
              sy[j] += longint'(pts_y[i]) * w;
              sz[j] += longint'(pts_z[i]) * w;
              ws[i] += w;
              ws[j] += w;
            end
          end
        end
      end
      for (int i = 0; i < loaded; i++) begin
        r.out_x    = rounded_mean(sx[i], ws[i]);
        r.out_y    = rounded_mean(sy[i], ws[i]);
        r.out_z    = rounded_mean(sz[i], ws[i]);
        r.last_out = (i + 1 == loaded);
        r.overflow = dropped;
        smoothed_q = {smoothed_q, r};
      end
      loaded  = 0;
      dropped = 0;
      sets_done++;
    endfunction

    function void check_result(eks_pkg::out_item_t got);
      eks_pkg::out_item_t want;
      checked++;
      if (smoothed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: x=%h y=%h z=%h last=%b ovf=%b",
                   got.out_x, got.out_y, got.out_z, got.last_out, got.overflow);
        return;
      end
      want = smoothed_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: exp x=%h y=%h z=%h l=%b o=%b got x=%h y=%h z=%h l=%b o=%b",
                   checked, want.out_x, want.out_y, want.out_z, want.last_out,
                   want.overflow, got.out_x, got.out_y, got.out_z, got.last_out,
                   got.overflow);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  bit          idle_on;
  int          items_sent;
  int          cycles;
  int          ready_hold;

  eks_in_if  in_ch ();
  eks_out_if out_ch ();

  smoothing_scoreboard sb = new();

  exponential_kernel_point_smoothing dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("exponential_kernel_point_smoothing_tb: FAIL");
      $finish;
    end
  end

  // result sink with random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      ready_hold <= 0;
      out_ch.ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ch.ready <= (ready_hold == 1);
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      ready_hold <= $urandom_range(1, 13);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  task automatic reg_write(logic idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic fin);
    eks_pkg::in_item_t it;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.final_point = fin;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(it);
    items_sent++;
    if (items_sent > ITEM_GOAL - QUIET_ITEMS) idle_on = 0;
  endtask

  // wait until the set is out, then a short settle time
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.smoothed_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic config_both(logic [31:0] sf, logic [31:0] cr);
    drain();
    reg_write(eks_pkg::REG_SMOOTH, sf);
    reg_write(eks_pkg::REG_CUTOFF, cr);
  endtask

  // clustered set with random content, some duplicates and some outliers
  task automatic send_cluster(int n);
    longint      span;
    logic [31:0] bx, by, bz, px, py, pz;
    span = (sb.cut_radius > 32'h0040_0000) ? 32'h0040_0000 : sb.cut_radius;
    bx = $urandom;
    by = $urandom;
    bz = $urandom;
    px = bx;
    py = by;
    pz = bz;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        // repeat the previous point
      end else if ($urandom_range(0, 9) == 0) begin
        px = $urandom;
        py = $urandom;
        pz = $urandom;
      end else begin
        px = bx + 32'(longint'($urandom_range(0, 32'(span))) - span / 2);
        py = by + 32'(longint'($urandom_range(0, 32'(span))) - span / 2);
        pz = bz + 32'(longint'($urandom_range(0, 32'(span))) - span / 2);
      end
      send_point(px, py, pz, i == n - 1);
    end
  endtask

  function automatic logic [31:0] pick_value(logic [31:0] dflt);
    case ($urandom_range(0, 6))
      0: return 32'd0;
      1: return 32'd1;
      2: return dflt;
      3: return 32'hFFFF_FFFF;
      4: return $urandom;
      default: return $urandom_range(1, 32'h0010_0000);
    endcase
  endfunction

  initial begin
    int phase;
    rst_n       <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    idle_on     = 1;
    items_sent  = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single points at the coordinate extremes pass unchanged
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    // identical pair, a close group of three, a far pair
    send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0, 1'b0);
    send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0, 1'b1);
    send_point(32'h0, 32'h0, 32'h0, 1'b0);
    send_point(32'h0001_0000, 32'h0, 32'h0, 1'b0);
    send_point(32'h0002_0000, 32'h0, 32'h8000, 1'b1);
    send_point(32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0);
    send_point(32'h8000_0000, 32'h0, 32'h0, 1'b1);

    // zero decay length disables smoothing
    config_both(32'd0, 32'hFFFF_FFFF);
    send_point(32'h0, 32'h0, 32'h0, 1'b0);
    send_point(32'h0000_8000, 32'h0, 32'h0, 1'b1);

    // widest cutoff: squared distance exceeds 64 bits and is rejected
    config_both(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000, 1'b1);

    // tiny decay length, and a zero cutoff that keeps only coincident points
    config_both(32'd1, 32'h0010_0000);
    send_point(32'h0, 32'h0, 32'h0, 1'b0);
    send_point(32'h1, 32'h0, 32'h0, 1'b1);
    config_both(32'd65536, 32'd0);
    send_point(32'h1234_5678, 32'h0, 32'h0, 1'b0);
    send_point(32'h1234_5678, 32'h0, 32'h0, 1'b0);
    send_point(32'h1234_5679, 32'h0, 32'h0, 1'b1);

    // random phases of register settings and clustered sets
    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      if (phase == 2) begin
        // full capacity plus dropped points
        config_both(eks_pkg::SMOOTH_RST, eks_pkg::CUTOFF_RST);
        send_cluster(NPTS + 2);
      end else begin
        config_both(pick_value(eks_pkg::SMOOTH_RST), pick_value(eks_pkg::CUTOFF_RST));
        repeat (3) send_cluster(($urandom_range(0, 5) == 0) ? $urandom_range(9, 16)
                                                            : $urandom_range(1, 8));
      end
      phase++;
    end
    drain();

    $display("sent %0d points in %0d sets over %0d register phases", items_sent,
             sb.sets_done, phase + 5);
    $display("checked %0d smoothed points, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.smoothed_q.size() == 0) begin
      $display("exponential_kernel_point_smoothing_tb: PASS");
    end else begin
      $display("exponential_kernel_point_smoothing_tb: FAIL");
    end
    $finish;
  end

endmodule

[exponential_kernel_point_smoothing.f]
hw/rtl/eks_pkg.sv
hw/rtl/eks_if.sv
hw/rtl/eks_div.sv
hw/rtl/exponential_kernel_point_smoothing.sv
hw/rtl/eks_chk.sv
tb/sv/exponential_kernel_point_smoothing_tb.sv
